FILE: rtl/core/text_console_writer_macros.svh
// Assertion macros for the text console writer.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH
`ifndef SYNTHESIS
// Check that the consequent holds in the same cycle as the antecedent
`define TCW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("text console check failed");
// Check that the consequent holds in the cycle after the antecedent
`define TCW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("text console check failed");
`else
`define TCW_ASSERT_IMP(lbl, ante, cons)
`define TCW_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/tcw_pkg.sv
// Shared constants, codes and controller/datapath interface types
// for the text console writer. No dependencies.
`default_nettype none

package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELLS       = COLUMNS * ROWS;
  localparam int SHIFT_CELLS = CELLS - COLUMNS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);

  // Port field widths
  localparam int OP_W   = 2;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 11;
  localparam int POS_W  = 11;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Character codes and reset values
  localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [BYTE_W-1:0] BLANK_CODE   = 8'd32;
  localparam logic [BYTE_W-1:0] ATTR_RESET   = 8'h07;
  localparam int                POS_LAST     = CELLS - 1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUT  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ = 2'd1;
  localparam logic [OP_W-1:0] OP_SET  = 2'd2;

  // Register index (word address bit)
  localparam logic REG_TEXT_ATTR = 1'b0;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;     // item taken this cycle
    logic put;        // write cell at cursor and advance
    logic rd_cell;    // read the requested cell
    logic set_start;  // load remainder for cursor set
    logic set_step;   // subtract one row from remainder
    logic set_end;    // remainder becomes column
    logic clear_wr;   // reset sweep write
    logic scroll_step;
    logic cnt_inc;
    logic cnt_clr;
    logic load_out;   // capture result payload
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scroll_needed;
    logic rem_ge_cols;
    logic clear_last;
    logic scroll_last;
  } dp_status_t;

  // Clamp a requested linear cell to the last cell
  function automatic logic [ADDR_W-1:0] clamp_cell(logic [IDX_W-1:0] idx);
    logic [ADDR_W-1:0] res;
    if (32'(idx) >= CELLS) begin
      res = ADDR_W'(CELLS - 1);
    end else begin
      res = ADDR_W'(idx);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tcw_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/tcw_ctrl.sv
// Sequencing state machine for the text console writer.
// Depends on tcw_pkg; drives tcw_dp through command and status structs.
`default_nettype none

module tcw_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [tcw_pkg::OP_W-1:0]    in_operation_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  input  wire tcw_pkg::dp_status_t         status_i,
  output tcw_pkg::ctrl_cmd_t               cmd_o
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCROLL = 3'd2;
  localparam logic [2:0] ST_DIVIDE = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (status_i.clear_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_RESULT;
          case (in_operation_i)
            tcw_pkg::OP_PUT: begin
              cmd_o.put = 1'b1;
              if (status_i.scroll_needed) begin
                state_d = ST_SCROLL;
              end
            end
            tcw_pkg::OP_READ: begin
              cmd_o.rd_cell = 1'b1;
            end
            tcw_pkg::OP_SET: begin
              cmd_o.set_start = 1'b1;
              state_d         = ST_DIVIDE;
            end
            default: begin
              state_d = ST_RESULT;
            end
          endcase
        end
      end
      ST_SCROLL: begin
        cmd_o.scroll_step = 1'b1;
        if (status_i.scroll_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_RESULT;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      ST_DIVIDE: begin
        if (status_i.rem_ge_cols) begin
          cmd_o.set_step = 1'b1;
        end else begin
          cmd_o.set_end = 1'b1;
          state_d       = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold the result until taken, raise it when loaded
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tcw_dp.sv
// Datapath for the text console writer: cursor, attribute register,
// sweep counter, character and attribute stores. Depends on tcw_pkg, tcw_ram.
`default_nettype none

module tcw_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire tcw_pkg::ctrl_cmd_t             cmd_i,
  output tcw_pkg::dp_status_t                 status_o,
  input  wire logic [tcw_pkg::BYTE_W-1:0]     char_code_i,
  input  wire logic [tcw_pkg::IDX_W-1:0]      cell_index_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [tcw_pkg::BYTE_W-1:0]     cfg_wdata_i,
  output logic      [tcw_pkg::BYTE_W-1:0]     text_attr_o,
  output logic      [tcw_pkg::POS_W-1:0]      cursor_position_o,
  output logic      [tcw_pkg::BYTE_W-1:0]     cell_char_o,
  output logic      [tcw_pkg::BYTE_W-1:0]     cell_attr_o
);

  localparam int AW = tcw_pkg::ADDR_W;
  localparam int BW = tcw_pkg::BYTE_W;

  logic [tcw_pkg::COL_W-1:0] col_q, col_d;
  logic [tcw_pkg::ROW_W-1:0] row_q, row_d;
  logic [AW-1:0]             rem_q, rem_d;
  logic [tcw_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [BW-1:0]             attr_q;
  logic                      rd_sel_q;
  logic [tcw_pkg::POS_W-1:0] pos_q;
  logic [BW-1:0]             cell_char_q, cell_attr_q;

  logic [AW-1:0] cur_cell, req_cell;
  logic          is_newline, col_last, row_last;

  logic          ch_we, at_we, ch_re, at_re;
  logic [AW-1:0] ch_waddr, at_waddr, ch_raddr;
  logic [BW-1:0] ch_wdata, at_wdata, ch_rdata, at_rdata;

  assign cur_cell   = AW'(32'(row_q) * tcw_pkg::COLUMNS + 32'(col_q));
  assign req_cell   = tcw_pkg::clamp_cell(cell_index_i);
  assign is_newline = (char_code_i == tcw_pkg::NEWLINE_CODE);
  assign col_last   = (col_q == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1));
  assign row_last   = (row_q == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));

  // Status towards the controller
  always_comb begin
    status_o.scroll_needed = (is_newline || col_last) && row_last;
    status_o.rem_ge_cols   = (rem_q >= AW'(tcw_pkg::COLUMNS));
    status_o.clear_last    = (cnt_q == tcw_pkg::CNT_W'(tcw_pkg::CELLS - 1));
    status_o.scroll_last   = (cnt_q == tcw_pkg::CNT_W'(tcw_pkg::CELLS));
  end

  // Advance, set and divide the cursor
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    rem_d = rem_q;
    if (cmd_i.put) begin
      if (is_newline || col_last) begin
        col_d = '0;
        if (!row_last) begin
          row_d = row_q + 1'b1;
        end
      end else begin
        col_d = col_q + 1'b1;
      end
    end
    if (cmd_i.set_start) begin
      rem_d = req_cell;
      row_d = '0;
    end
    if (cmd_i.set_step) begin
      rem_d = rem_q - AW'(tcw_pkg::COLUMNS);
      row_d = row_q + 1'b1;
    end
    if (cmd_i.set_end) begin
      col_d = tcw_pkg::COL_W'(rem_q);
    end
  end

  // Sweep counter for clearing and scrolling
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  // Store port selection
  always_comb begin
    ch_we    = 1'b0;
    at_we    = 1'b0;
    ch_re    = 1'b0;
    at_re    = 1'b0;
    ch_waddr = cur_cell;
    at_waddr = cur_cell;
    ch_wdata = char_code_i;
    at_wdata = attr_q;
    ch_raddr = req_cell;
    if (cmd_i.clear_wr) begin
      ch_we    = 1'b1;
      at_we    = 1'b1;
      ch_waddr = cnt_q[AW-1:0];
      at_waddr = cnt_q[AW-1:0];
      ch_wdata = '0;
      at_wdata = '0;
    end
    if (cmd_i.put && !is_newline) begin
      ch_we = 1'b1;
      at_we = 1'b1;
    end
    if (cmd_i.rd_cell) begin
      ch_re = 1'b1;
      at_re = 1'b1;
    end
    // Scroll: read one row ahead, write the previous cell, blank the bottom row
    if (cmd_i.scroll_step) begin
      if (cnt_q < tcw_pkg::CNT_W'(tcw_pkg::SHIFT_CELLS)) begin
        ch_re    = 1'b1;
        ch_raddr = AW'(cnt_q + tcw_pkg::CNT_W'(tcw_pkg::COLUMNS));
      end
      if (cnt_q != '0) begin
        ch_we    = 1'b1;
        ch_waddr = AW'(cnt_q - 1'b1);
        if (cnt_q <= tcw_pkg::CNT_W'(tcw_pkg::SHIFT_CELLS)) begin
          ch_wdata = ch_rdata;
        end else begin
          ch_wdata = tcw_pkg::BLANK_CODE;
        end
      end
    end
  end

  tcw_ram #(
    .WIDTH(BW),
    .DEPTH(tcw_pkg::CELLS)
  ) u_char_ram (
    .clk_i  (clk_i),
    .we_i   (ch_we),
    .waddr_i(ch_waddr),
    .wdata_i(ch_wdata),
    .re_i   (ch_re),
    .raddr_i(ch_raddr),
    .rdata_o(ch_rdata)
  );

  tcw_ram #(
    .WIDTH(BW),
    .DEPTH(tcw_pkg::CELLS)
  ) u_attr_ram (
    .clk_i  (clk_i),
    .we_i   (at_we),
    .waddr_i(at_waddr),
    .wdata_i(at_wdata),
    .re_i   (at_re),
    .raddr_i(req_cell),
    .rdata_o(at_rdata)
  );

  // Control and cursor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      cnt_q  <= '0;
      attr_q <= tcw_pkg::ATTR_RESET;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    if (cmd_i.accept) begin
      rd_sel_q <= cmd_i.rd_cell;
    end
    if (cmd_i.load_out) begin
      pos_q       <= tcw_pkg::POS_W'(cur_cell);
      cell_char_q <= rd_sel_q ? ch_rdata : '0;
      cell_attr_q <= rd_sel_q ? at_rdata : '0;
    end
  end

  assign text_attr_o       = attr_q;
  assign cursor_position_o = pos_q;
  assign cell_char_o       = cell_char_q;
  assign cell_attr_o       = cell_attr_q;

endmodule

`default_nettype wire

FILE: rtl/core/text_console_writer.sv
// Top level of the text console writer: APB register decode, controller
// and datapath. Depends on tcw_pkg, tcw_ctrl, tcw_dp, text_console_writer_macros.svh.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid_i/in_stall_o  operation, char_code, cell_index
//   out      source     out_valid_o/out_stall_i cursor_position, cell_char, cell_attr
//   cfg      APB slave  psel/penable/pready    text_attribute at byte 0
//
// After reset both stores are cleared one cell a cycle, with in_stall_o high.
// Set-cursor finds the row by subtracting one row from the position at a time.
// A put that runs off the bottom row moves the character store up a row, one cell
// a cycle through the single write port.
// A new item is taken while the previous result waits in the output register;
// that item completes once the output register is free.
`default_nettype none

`include "text_console_writer_macros.svh"

module text_console_writer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [tcw_pkg::OP_W-1:0]      in_operation_i,
  input  wire logic [tcw_pkg::BYTE_W-1:0]    in_char_code_i,
  input  wire logic [tcw_pkg::IDX_W-1:0]     in_cell_index_i,
  // Output channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [tcw_pkg::POS_W-1:0]     out_cursor_position_o,
  output logic      [tcw_pkg::BYTE_W-1:0]    out_cell_char_o,
  output logic      [tcw_pkg::BYTE_W-1:0]    out_cell_attr_o,
  // Configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tcw_pkg::APB_AW-1:0]    paddr,
  input  wire logic [tcw_pkg::APB_DW-1:0]    pwdata,
  output logic      [tcw_pkg::APB_DW-1:0]    prdata,
  output logic                               pready
);

  tcw_pkg::ctrl_cmd_t  cmd;
  tcw_pkg::dp_status_t status;
  logic                cfg_we;
  logic [tcw_pkg::BYTE_W-1:0] text_attr;

  // Register decode
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == tcw_pkg::REG_TEXT_ATTR);

  always_comb begin
    prdata = '0;
    if (paddr[2] == tcw_pkg::REG_TEXT_ATTR) begin
      prdata = tcw_pkg::APB_DW'(text_attr);
    end
  end

  tcw_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_operation_i(in_operation_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  tcw_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .char_code_i      (in_char_code_i),
    .cell_index_i     (in_cell_index_i),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (pwdata[tcw_pkg::BYTE_W-1:0]),
    .text_attr_o      (text_attr),
    .cursor_position_o(out_cursor_position_o),
    .cell_char_o      (out_cell_char_o),
    .cell_attr_o      (out_cell_attr_o)
  );

  // Busy after every accepted transaction
  `TCW_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  // A result is raised only out of a busy cycle
  `TCW_ASSERT_IMP(a_result_after_work, $rose(out_valid_o), $past(in_stall_o))
  // Reported cursor stays on the screen
  `TCW_ASSERT_IMP(a_cursor_on_screen, out_valid_o, out_cursor_position_o <= tcw_pkg::POS_LAST)

endmodule

`default_nettype wire

FILE: test/text_console_writer_checker.sv
// Checker for the text console writer: keeps its own copy of the screen,
// cursor and attribute register, predicts each reply and compares it with
// the output channel. Depends on tcw_pkg.
module text_console_writer_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [tcw_pkg::OP_W-1:0]       in_operation_i,
  input  logic [tcw_pkg::BYTE_W-1:0]     in_char_code_i,
  input  logic [tcw_pkg::IDX_W-1:0]      in_cell_index_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [tcw_pkg::POS_W-1:0]      out_cursor_position_i,
  input  logic [tcw_pkg::BYTE_W-1:0]     out_cell_char_i,
  input  logic [tcw_pkg::BYTE_W-1:0]     out_cell_attr_i,
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic                           pready_i,
  input  logic [tcw_pkg::APB_AW-1:0]     paddr_i,
  input  logic [tcw_pkg::APB_DW-1:0]     pwdata_i,
  input  logic [tcw_pkg::APB_DW-1:0]     prdata_i,
  output int                             pending_o,
  output int                             errors_o,
  output int                             scrolls_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0]  cursor;
    logic [BYTE_W-1:0] glyph;
    logic [BYTE_W-1:0] tint;
  } console_reply_t;

  localparam logic [APB_AW-1:0] ATTR_ADDR = {REG_TEXT_ATTR, 2'b00};

  logic [BYTE_W-1:0] glyph_mem [CELLS];
  logic [BYTE_W-1:0] tint_mem  [CELLS];
  logic [BYTE_W-1:0] text_attr;
  int                cur_col;
  int                cur_row;
  int                mismatches;
  int                scrolls;
  console_reply_t    replies_due [$];

  assign errors_o  = mismatches;
  assign scrolls_o = scrolls;

  // Count a failure; print only the first few
  task automatic report_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  // Apply one command to the shadow console and return the reply it gives
  function automatic console_reply_t apply_command(logic [OP_W-1:0] op,
                                                   logic [BYTE_W-1:0] code,
                                                   logic [IDX_W-1:0] idx);
    console_reply_t reply;
    int             slot;
    reply = '0;
    slot  = (int'(idx) > POS_LAST) ? POS_LAST : int'(idx);
    case (op)
      OP_PUT: begin
        if (code != NEWLINE_CODE) begin
          glyph_mem[cur_row * COLUMNS + cur_col] = code;
          tint_mem[cur_row * COLUMNS + cur_col]  = text_attr;
          cur_col++;
        end else begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        // Scroll characters up a row; attributes stay where they are
        if (cur_row >= ROWS) begin
          for (int i = 0; i < SHIFT_CELLS; i++) glyph_mem[i] = glyph_mem[i + COLUMNS];
          for (int i = SHIFT_CELLS; i < CELLS; i++) glyph_mem[i] = BLANK_CODE;
          cur_row = ROWS - 1;
          cur_col = 0;
          scrolls++;
        end
      end
      OP_READ: begin
        reply.glyph = glyph_mem[slot];
        reply.tint  = tint_mem[slot];
      end
      OP_SET: begin
        cur_col = slot % COLUMNS;
        cur_row = slot / COLUMNS;
      end
      default: ;
    endcase
    reply.cursor = POS_W'(cur_row * COLUMNS + cur_col);
    return reply;
  endfunction

  // Track register accesses, predict on input transactions, compare on output ones
  always @(posedge clk_i or negedge rst_ni) begin
    console_reply_t want;
    if (!rst_ni) begin
      for (int i = 0; i < CELLS; i++) begin
        glyph_mem[i] = '0;
        tint_mem[i]  = '0;
      end
      text_attr  = ATTR_RESET;
      cur_col    = 0;
      cur_row    = 0;
      mismatches = 0;
      scrolls    = 0;
      replies_due.delete();
    end else begin
      if (psel_i && penable_i && pready_i && paddr_i == ATTR_ADDR) begin
        if (pwrite_i) begin
          text_attr = pwdata_i[BYTE_W-1:0];
        end else if (prdata_i[BYTE_W-1:0] !== text_attr) begin
          report_mismatch("text_attribute readback", text_attr, prdata_i[BYTE_W-1:0]);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        replies_due.push_back(apply_command(in_operation_i, in_char_code_i, in_cell_index_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (replies_due.size() == 0) begin
          report_mismatch("unexpected reply, cursor_position", -1, out_cursor_position_i);
        end else begin
          want = replies_due.pop_front();
          if (out_cursor_position_i !== want.cursor) begin
            report_mismatch("cursor_position", want.cursor, out_cursor_position_i);
          end
          if (out_cell_char_i !== want.glyph) begin
            report_mismatch("cell_char", want.glyph, out_cell_char_i);
          end
          if (out_cell_attr_i !== want.tint) begin
            report_mismatch("cell_attr", want.tint, out_cell_attr_i);
          end
        end
      end
    end
    pending_o <= replies_due.size();
  end

endmodule

FILE: test/text_console_writer_tb.sv
// Top of the text console writer testbench: clock, reset, command stimulus,
// receiver stalls, register programming and the verdict.
// Depends on tcw_pkg, text_console_writer and text_console_writer_checker.
module text_console_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam logic [OP_W-1:0]   OP_UNUSED       = 2'd3;
  localparam logic [APB_AW-1:0] ATTR_ADDR       = {REG_TEXT_ATTR, 2'b00};
  localparam int                PHASES          = 6;
  localparam int                ITEMS_PER_PHASE = 125;
  localparam int                WATCHDOG_LIMIT  = 20000;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic [OP_W-1:0]    in_op      = '0;
  logic [BYTE_W-1:0]  in_code    = '0;
  logic [IDX_W-1:0]   in_idx     = '0;
  logic               out_stall  = 1'b0;
  logic               psel       = 1'b0;
  logic               penable    = 1'b0;
  logic               pwrite     = 1'b0;
  logic [APB_AW-1:0]  paddr      = '0;
  logic [APB_DW-1:0]  pwdata     = '0;

  logic               in_stall;
  logic               out_valid;
  logic [POS_W-1:0]   out_cursor;
  logic [BYTE_W-1:0]  out_char;
  logic [BYTE_W-1:0]  out_attr;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  int pending;
  int errors;
  int scrolls;
  int idle_cycles = 0;
  int op_tally [4] = '{0, 0, 0, 0};
  int settings_used = 1;
  int burst_left = 0;
  int stall_tick = 0;
  int stall_mode = 0;
  int stall_run  = 0;
  logic stall_hold = 1'b0;

  text_console_writer uut (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .in_valid_i            (in_valid),
    .in_stall_o            (in_stall),
    .in_operation_i        (in_op),
    .in_char_code_i        (in_code),
    .in_cell_index_i       (in_idx),
    .out_valid_o           (out_valid),
    .out_stall_i           (out_stall),
    .out_cursor_position_o (out_cursor),
    .out_cell_char_o       (out_char),
    .out_cell_attr_o       (out_attr),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  text_console_writer_checker checker_inst (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .in_valid_i            (in_valid),
    .in_stall_i            (in_stall),
    .in_operation_i        (in_op),
    .in_char_code_i        (in_code),
    .in_cell_index_i       (in_idx),
    .out_valid_i           (out_valid),
    .out_stall_i           (out_stall),
    .out_cursor_position_i (out_cursor),
    .out_cell_char_i       (out_char),
    .out_cell_attr_i       (out_attr),
    .psel_i                (psel),
    .penable_i             (penable),
    .pwrite_i              (pwrite),
    .pready_i              (pready),
    .paddr_i               (paddr),
    .pwdata_i              (pwdata),
    .prdata_i              (prdata),
    .pending_o             (pending),
    .errors_o              (errors),
    .scrolls_o             (scrolls)
  );

  // Free-running clock
  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver stalls: modes of no stall, scattered stalls and long runs
  always @(posedge clk) begin
    stall_tick++;
    if (stall_tick % 300 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: begin
        if (stall_run == 0) begin
          stall_hold = ~stall_hold;
          stall_run  = $urandom_range(1, 8);
        end
        stall_run--;
        out_stall <= stall_hold;
      end
    endcase
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one command and hold it until the block takes it
  task automatic send_command(logic [OP_W-1:0] op, logic [BYTE_W-1:0] code,
                              logic [IDX_W-1:0] idx);
    in_valid <= 1'b1;
    in_op    <= op;
    in_code  <= code;
    in_idx   <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    op_tally[op]++;
  endtask

  task automatic idle_for(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted reply has been taken
  task automatic drain_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One APB transfer on the attribute register, setup then access
  task automatic apb_access(logic wr, logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ATTR_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Program the attribute while the console is idle, then read it back
  task automatic program_attr(logic [BYTE_W-1:0] value);
    drain_replies();
    repeat (4) @(posedge clk);
    apb_access(1'b1, APB_DW'(value));
    apb_access(1'b0, '0);
    settings_used++;
  endtask

  // Random command, biased towards the bottom rows so that scrolls happen
  task automatic random_command();
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] code;
    logic [IDX_W-1:0]  idx;
    int                pick;
    pick = $urandom_range(0, 99);
    code = BYTE_W'($urandom);
    idx  = IDX_W'($urandom);
    if (pick < 55) begin
      op = OP_PUT;
      if ($urandom_range(0, 7) == 0) code = NEWLINE_CODE;
    end else if (pick < 77) begin
      op = OP_READ;
      if ($urandom_range(0, 9) != 0) idx = IDX_W'($urandom_range(0, POS_LAST));
    end else if (pick < 95) begin
      op = OP_SET;
      case ($urandom_range(0, 5))
        0: ;
        1, 2: idx = IDX_W'($urandom_range(POS_LAST - 2 * COLUMNS + 1, POS_LAST));
        default: idx = IDX_W'($urandom_range(0, POS_LAST));
      endcase
    end else begin
      op = OP_UNUSED;
    end
    send_command(op, code, idx);
  endtask

  initial begin
    logic [BYTE_W-1:0] phase_attr;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset contents, clamping, unused code, byte extremes, newline
    apb_access(1'b0, '0);
    send_command(OP_READ, 8'h00, 11'd0);
    send_command(OP_READ, 8'h00, IDX_W'(POS_LAST));
    send_command(OP_READ, 8'hFF, 11'h7FF);
    send_command(OP_UNUSED, 8'hFF, 11'h7FF);
    send_command(OP_PUT, 8'h41, 11'd0);
    send_command(OP_PUT, 8'h00, 11'h7FF);
    send_command(OP_PUT, 8'hFF, 11'd0);
    send_command(OP_PUT, NEWLINE_CODE, 11'd0);
    send_command(OP_READ, 8'h00, 11'd0);
    send_command(OP_READ, 8'h00, 11'd2);
    send_command(OP_READ, 8'h00, 11'd3);

    // Column wrap with the attribute at zero
    program_attr(8'h00);
    send_command(OP_SET, 8'h00, IDX_W'(COLUMNS - 1));
    send_command(OP_PUT, 8'h55, 11'd0);
    send_command(OP_READ, 8'h00, IDX_W'(COLUMNS - 1));

    // Scrolls from the last cell and by newline on the bottom row
    program_attr(8'hFF);
    send_command(OP_SET, 8'h00, 11'h7FF);
    send_command(OP_PUT, 8'hAA, 11'd0);
    send_command(OP_READ, 8'h00, IDX_W'(POS_LAST));
    send_command(OP_READ, 8'h00, IDX_W'(POS_LAST - COLUMNS));
    send_command(OP_SET, 8'h00, IDX_W'(SHIFT_CELLS));
    send_command(OP_PUT, NEWLINE_CODE, 11'd0);
    send_command(OP_SET, 8'h00, IDX_W'(SHIFT_CELLS - 1));
    send_command(OP_PUT, 8'h7E, 11'd0);
    send_command(OP_PUT, NEWLINE_CODE, 11'd0);
    send_command(OP_READ, 8'h00, IDX_W'(SHIFT_CELLS - 1));

    // Random phases, one attribute setting each
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: phase_attr = 8'h00;
        1: phase_attr = 8'hFF;
        3: phase_attr = 8'h80;
        5: phase_attr = 8'h01;
        default: phase_attr = BYTE_W'($urandom);
      endcase
      program_attr(phase_attr);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 10));
          burst_left = $urandom_range(1, 40);
        end
        if ($urandom_range(0, 79) == 0) drain_replies();
        random_command();
        burst_left--;
      end
    end

    // Let the last replies out and settle
    drain_replies();
    repeat (20) @(posedge clk);

    $display("Covered %0d put, %0d read, %0d set and %0d unused commands",
             op_tally[OP_PUT], op_tally[OP_READ], op_tally[OP_SET], op_tally[OP_UNUSED]);
    $display("with %0d scrolls over %0d attribute settings", scrolls, settings_used);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
